// ===== rtl/track_path_length_accumulator_defines.svh =====
// ---------------------------------------------------------------------------
// track_path_length_accumulator_defines
// assertion macros used by the path length accumulator datapath
// ---------------------------------------------------------------------------
`ifndef TRACK_PATH_LENGTH_ACCUMULATOR_DEFINES_SVH
`define TRACK_PATH_LENGTH_ACCUMULATOR_DEFINES_SVH

// implication checked at every clock edge outside reset
`define TPLA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TPLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tpla_pkg.sv =====
// ---------------------------------------------------------------------------
// tpla_pkg
// widths, fix codes and controller/datapath interface types
// ---------------------------------------------------------------------------
package tpla_pkg;

  localparam int COORD_BITS = 24;
  localparam int COUNT_BITS = 20;
  localparam int PATH_BITS  = 40;
  localparam int OSUM_BITS  = 46;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int ROOT_BITS  = SQ_BITS / 2;
  localparam int DIST_BITS  = COORD_BITS + 1;

  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_STOP  = 2'd2;

  typedef struct packed {
    logic load;
    logic start;
    logic diff;
    logic square;
    logic root_start;
    logic accum;
    logic div_start;
    logic out_load;
  } tpla_cmd_t;

  typedef struct packed {
    logic running;
    logic is_start;
    logic is_stop;
    logic root_busy;
    logic div_busy;
    logic out_free;
  } tpla_stat_t;

  // magnitude of a - b
  function automatic logic [DIFF_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(a) - DIFF_BITS'(b);
    if (d < 0) begin
      abs_diff = DIFF_BITS'(-d);
    end else begin
      abs_diff = DIFF_BITS'(d);
    end
  endfunction

endpackage

// ===== rtl/tpla_sqrt.sv =====
// ---------------------------------------------------------------------------
// tpla_sqrt
// floored integer square root, one root bit per cycle
// ---------------------------------------------------------------------------
module tpla_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [tpla_pkg::SQ_BITS-1:0]   radicand,
  output logic                           busy,
  output logic [tpla_pkg::ROOT_BITS-1:0] root
);
  import tpla_pkg::*;

  localparam int CNT_BITS = $clog2(ROOT_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(ROOT_BITS - 1);

  logic [SQ_BITS-1:0]     rad;
  logic [ROOT_BITS+1:0]   rem;
  logic [CNT_BITS-1:0]    cnt;
  logic [ROOT_BITS+3:0]   rem_sh;
  logic [ROOT_BITS+3:0]   trial;
  logic                   fits;

  assign rem_sh = {rem, rad[SQ_BITS-1 -: 2]};
  assign trial  = (ROOT_BITS+4)'({root, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[SQ_BITS-3:0], 2'b00};
      if (fits) begin
        rem  <= (ROOT_BITS+2)'(rem_sh - trial);
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[ROOT_BITS+1:0];
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tpla_div.sv =====
// ---------------------------------------------------------------------------
// tpla_div
// restoring divider for the mean origin distance, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tpla_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [tpla_pkg::OSUM_BITS-1:0]  dividend,
  input  logic [tpla_pkg::COUNT_BITS-1:0] divisor,
  output logic                            busy,
  output logic [tpla_pkg::OSUM_BITS-1:0]  quotient
);
  import tpla_pkg::*;

  localparam int CNT_BITS = $clog2(OSUM_BITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(OSUM_BITS - 1);

  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS-1:0] rem;
  logic [CNT_BITS-1:0]   cnt;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  fits;

  // dividend bits shift out of the top while quotient bits shift in below
  assign rem_sh = {rem, quotient[OSUM_BITS-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= COUNT_BITS'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[COUNT_BITS-1:0];
      end
      quotient <= {quotient[OSUM_BITS-2:0], fits};
      cnt      <= cnt + 1'b1;
      if (cnt == LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tpla_ctrl.sv =====
// ---------------------------------------------------------------------------
// tpla_ctrl
// sequencer for one fix: decide, square, root, accumulate, divide, output
// ---------------------------------------------------------------------------
module tpla_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tpla_pkg::tpla_stat_t stat,
  output tpla_pkg::tpla_cmd_t  cmd
);
  import tpla_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SQUARE, S_ROOTGO, S_ROOT, S_ACC, S_DIVGO, S_DIV, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.running) begin
          cmd.diff   = 1'b1;
          state_next = S_SQUARE;
        end else begin
          cmd.start  = stat.is_start;
          state_next = S_IDLE;
        end
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ROOTGO;
      end
      S_ROOTGO: begin
        cmd.root_start = 1'b1;
        state_next     = S_ROOT;
      end
      S_ROOT: begin
        if (!stat.root_busy) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        state_next = stat.is_stop ? S_DIVGO : S_IDLE;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/tpla_dp.sv =====
// ---------------------------------------------------------------------------
// tpla_dp
// datapath: fix registers, squares, two root units, sums, divider, output
// ---------------------------------------------------------------------------
`include "track_path_length_accumulator_defines.svh"

module tpla_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tpla_pkg::tpla_cmd_t                    cmd,
  output tpla_pkg::tpla_stat_t                   stat,
  input  logic [1:0]                             func,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] pos_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tpla_pkg::COORD_BITS-1:0] final_x,
  output logic signed [tpla_pkg::COORD_BITS-1:0] final_y,
  output logic [tpla_pkg::PATH_BITS-1:0]         path_total,
  output logic [tpla_pkg::DIST_BITS-1:0]         origin_distance,
  output logic [tpla_pkg::DIST_BITS-1:0]         mean_origin_distance,
  output logic [tpla_pkg::COUNT_BITS-1:0]        fix_count,
  output logic                                   overflow
);
  import tpla_pkg::*;

  logic [1:0]                    cur_func;
  logic signed [COORD_BITS-1:0]  cur_x, cur_y, origin_x, origin_y, last_x, last_y;
  logic [DIFF_BITS-1:0]          dpx, dpy, dox, doy;
  logic [SQ_BITS-1:0]            sq_px, sq_py, sq_ox, sq_oy;
  logic [PATH_BITS-1:0]          path_sum;
  logic [OSUM_BITS-1:0]          origin_sum;
  logic [COUNT_BITS-1:0]         tally;
  logic [ROOT_BITS-1:0]          odist;
  logic                          sat_flag;
  logic                          running;
  logic                          path_busy, orig_busy, div_busy;
  logic [ROOT_BITS-1:0]          path_root, orig_root;
  logic [OSUM_BITS-1:0]          quot;
  logic [PATH_BITS:0]            path_ext;
  logic [OSUM_BITS:0]            osum_ext;
  logic                          tally_full;

  tpla_sqrt u_path_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (sq_px + sq_py),
    .busy     (path_busy),
    .root     (path_root)
  );

  tpla_sqrt u_orig_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (sq_ox + sq_oy),
    .busy     (orig_busy),
    .root     (orig_root)
  );

  tpla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (origin_sum),
    .divisor  (tally),
    .busy     (div_busy),
    .quotient (quot)
  );

  assign path_ext   = {1'b0, path_sum} + (PATH_BITS+1)'(path_root);
  assign osum_ext   = {1'b0, origin_sum} + (OSUM_BITS+1)'(orig_root);
  assign tally_full = &tally;

  assign stat.running   = running;
  assign stat.is_start  = cur_func == FUNC_START;
  assign stat.is_stop   = cur_func == FUNC_STOP;
  assign stat.root_busy = path_busy | orig_busy;
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_func <= func;
      cur_x    <= pos_x;
      cur_y    <= pos_y;
    end
    if (cmd.diff) begin
      dpx <= abs_diff(last_x, cur_x);
      dpy <= abs_diff(last_y, cur_y);
      dox <= abs_diff(origin_x, cur_x);
      doy <= abs_diff(origin_y, cur_y);
    end
    if (cmd.square) begin
      sq_px <= dpx * dpx;
      sq_py <= dpy * dpy;
      sq_ox <= dox * dox;
      sq_oy <= doy * doy;
    end
    if (cmd.start) begin
      origin_x   <= cur_x;
      origin_y   <= cur_y;
      last_x     <= cur_x;
      last_y     <= cur_y;
      path_sum   <= '0;
      origin_sum <= '0;
      tally      <= '0;
      sat_flag   <= 1'b0;
    end
    if (cmd.accum) begin
      last_x   <= cur_x;
      last_y   <= cur_y;
      odist    <= orig_root;
      path_sum   <= path_ext[PATH_BITS] ? '1 : path_ext[PATH_BITS-1:0];
      origin_sum <= osum_ext[OSUM_BITS] ? '1 : osum_ext[OSUM_BITS-1:0];
      tally      <= tally_full ? tally : tally + 1'b1;
      sat_flag   <= sat_flag | path_ext[PATH_BITS] | osum_ext[OSUM_BITS] | tally_full;
    end
    if (cmd.out_load) begin
      final_x              <= cur_x;
      final_y              <= cur_y;
      path_total           <= path_sum;
      origin_distance      <= DIST_BITS'(odist);
      mean_origin_distance <= quot[DIST_BITS-1:0];
      fix_count            <= tally;
      overflow             <= sat_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        running <= 1'b1;
      end else if (cmd.accum && stat.is_stop) begin
        running <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TPLA_ASSERT_IMPL(a_div_nonzero, cmd.div_start, tally != '0, "divide started with zero count")
  `TPLA_ASSERT_IMPL(a_out_slot, cmd.out_load, !out_valid || !out_stall, "result overwritten")
  `TPLA_ASSERT_IMPL(a_root_idle, cmd.root_start, !path_busy && !orig_busy, "root restarted busy")
  `TPLA_ASSERT_NEXT(a_stop_idle, cmd.accum && stat.is_stop, !running, "stop left block running")

endmodule

// ===== rtl/track_path_length_accumulator.sv =====
// ---------------------------------------------------------------------------
// track_path_length_accumulator
// odometer over a stream of Q15.8 position fixes: path length, origin
// distance and mean origin distance, one result per trip-ending stop fix
// ---------------------------------------------------------------------------
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  in       in_valid, in_stall, func, pos_x, pos_y     into block
//  out      out_valid, out_stall, final_x .. overflow  out of block
//
//  one fix at a time: a fix seen while idle is only loaded and decided
//  a counted fix also runs the squares and the 25-step root units
//  a stop fix also runs the 46-step restoring divider
//  rst is synchronous, active high, and returns the block to idle
//  a held result waits in the output register; the last step of a stop
//  transaction waits there too until out_stall lets the result move
// ---------------------------------------------------------------------------
module track_path_length_accumulator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             func,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] pos_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tpla_pkg::COORD_BITS-1:0] final_x,
  output logic signed [tpla_pkg::COORD_BITS-1:0] final_y,
  output logic [tpla_pkg::PATH_BITS-1:0]         path_total,
  output logic [tpla_pkg::DIST_BITS-1:0]         origin_distance,
  output logic [tpla_pkg::DIST_BITS-1:0]         mean_origin_distance,
  output logic [tpla_pkg::COUNT_BITS-1:0]        fix_count,
  output logic                                   overflow
);
  import tpla_pkg::*;

  // commands from the sequencer, status back from the datapath
  tpla_cmd_t  cmd;
  tpla_stat_t stat;

  tpla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath holds all track state and the output register
  tpla_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .stat                 (stat),
    .func                 (func),
    .pos_x                (pos_x),
    .pos_y                (pos_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .final_x              (final_x),
    .final_y              (final_y),
    .path_total           (path_total),
    .origin_distance      (origin_distance),
    .mean_origin_distance (mean_origin_distance),
    .fix_count            (fix_count),
    .overflow             (overflow)
  );

endmodule

// ===== dv/tpla_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tpla_checker
// watches both channels, predicts the odometer result for every stop fix that
// closes a trip and compares each accepted result field by field
// ---------------------------------------------------------------------------
module tpla_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic                                   in_stall,
  input  logic [1:0]                             func,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] pos_y,
  input  logic                                   out_valid,
  input  logic                                   out_stall,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] final_x,
  input  logic signed [tpla_pkg::COORD_BITS-1:0] final_y,
  input  logic [tpla_pkg::PATH_BITS-1:0]         path_total,
  input  logic [tpla_pkg::DIST_BITS-1:0]         origin_distance,
  input  logic [tpla_pkg::DIST_BITS-1:0]         mean_origin_distance,
  input  logic [tpla_pkg::COUNT_BITS-1:0]        fix_count,
  input  logic                                   overflow,
  output int                                     fail_count,
  output int                                     pending,
  output int                                     trips_seen
);
  import tpla_pkg::*;

  typedef struct {
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
    logic [PATH_BITS-1:0]  path;
    logic [DIST_BITS-1:0]  odist;
    logic [DIST_BITS-1:0]  mean;
    logic [COUNT_BITS-1:0] cnt;
    logic                  ovf;
  } trip_t;

  trip_t trip_q[$];

  logic                          on_trip;
  logic signed [COORD_BITS-1:0]  org_x, org_y, prev_x, prev_y;
  logic [PATH_BITS-1:0]          path_acc;
  logic [OSUM_BITS-1:0]          odist_acc;
  logic [COUNT_BITS-1:0]         tally;
  logic                          sat;

  function automatic logic [63:0] step_len(logic signed [COORD_BITS-1:0] ax,
      logic signed [COORD_BITS-1:0] ay, logic signed [COORD_BITS-1:0] bx,
      logic signed [COORD_BITS-1:0] by);
    logic signed [33:0] dx, dy;
    logic [67:0] sq, rem, trial;
    logic [63:0] root;
    dx = 34'(ax) - 34'(bx);
    dy = 34'(ay) - 34'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy);
    rem = 0;
    root = 0;
    for (int i = 33; i >= 0; i--) begin
      rem = (rem << 2) | 68'((sq >> (2 * i)) & 68'd3);
      trial = 68'({root, 2'b01});
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    trips_seen = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    logic [63:0] sl, od;
    logic [64:0] sum;
    trip_t t;
    if (rst) begin
      on_trip <= 0; org_x <= 0; org_y <= 0; prev_x <= 0; prev_y <= 0;
      path_acc <= 0; odist_acc <= 0; tally <= 0; sat <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (!on_trip) begin
          if (func == FUNC_START) begin
            org_x <= pos_x; org_y <= pos_y; prev_x <= pos_x; prev_y <= pos_y;
            path_acc <= 0; odist_acc <= 0; tally <= 0; sat <= 0;
            on_trip <= 1;
          end
        end else begin
          t.ovf = sat;
          sl = step_len(prev_x, prev_y, pos_x, pos_y);
          sum = 65'(path_acc) + 65'(sl);
          if (sum > 65'({PATH_BITS{1'b1}})) begin
            t.path = '1; t.ovf = 1;
          end else t.path = sum[PATH_BITS-1:0];
          od = step_len(org_x, org_y, pos_x, pos_y);
          sum = 65'(odist_acc) + 65'(od);
          if (sum > 65'({OSUM_BITS{1'b1}})) begin
            sum = 65'({OSUM_BITS{1'b1}}); t.ovf = 1;
          end
          if (tally == '1) t.ovf = 1;
          else t.cnt = tally + 1'b1;
          if (tally == '1) t.cnt = tally;
          path_acc <= t.path;
          odist_acc <= sum[OSUM_BITS-1:0];
          tally <= t.cnt;
          sat <= t.ovf;
          prev_x <= pos_x; prev_y <= pos_y;
          // stop marker closes the trip and yields one result
          if (func == FUNC_STOP) begin
            on_trip <= 0;
            t.fx = pos_x; t.fy = pos_y;
            t.odist = od[DIST_BITS-1:0];
            t.mean = DIST_BITS'(sum[OSUM_BITS-1:0] / t.cnt);
            trip_q.push_back(t);
          end
        end
      end
      if (out_valid && !out_stall) begin
        trips_seen++;
        if (trip_q.size() == 0) begin
          $display("unexpected result transaction");
          fail_count++;
        end else begin
          t = trip_q.pop_front();
          if (final_x !== t.fx) report("final_x", final_x, t.fx);
          if (final_y !== t.fy) report("final_y", final_y, t.fy);
          if (path_total !== t.path) report("path_total", path_total, t.path);
          if (origin_distance !== t.odist)
            report("origin_distance", origin_distance, t.odist);
          if (mean_origin_distance !== t.mean)
            report("mean_origin_distance", mean_origin_distance, t.mean);
          if (fix_count !== t.cnt) report("fix_count", fix_count, t.cnt);
          if (overflow !== t.ovf) report("overflow", overflow, t.ovf);
        end
      end
    end
    pending = trip_q.size();
  end
endmodule

// ===== dv/tb_track_path_length_accumulator.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_track_path_length_accumulator
// drives directed and random trips of position fixes with bursty input and
// a patterned output stall; the checker predicts and compares every result
// ---------------------------------------------------------------------------
module tb_track_path_length_accumulator;
  import tpla_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] func = 0;
  logic signed [COORD_BITS-1:0] pos_x = 0, pos_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [COORD_BITS-1:0] final_x, final_y;
  logic [PATH_BITS-1:0] path_total;
  logic [DIST_BITS-1:0] origin_distance, mean_origin_distance;
  logic [COUNT_BITS-1:0] fix_count;
  logic overflow;
  int fail_count, pending, trips_seen;
  int fixes_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 0;

  localparam logic [1:0] FUNC_POINT = 2'd0;
  localparam logic [1:0] FUNC_ODD   = 2'd3;
  localparam int         WATCHDOG   = 20000;

  // clock: 4 ns period
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  track_path_length_accumulator u_top (.*);

  tpla_checker u_chk (.*);

  // send one fix, holding the payload until the transaction is taken
  task automatic send_fix(logic [1:0] f, logic signed [COORD_BITS-1:0] x,
                          logic signed [COORD_BITS-1:0] y);
    in_valid <= 1;
    func <= f;
    pos_x <= x;
    pos_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fixes_sent++;
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random coordinate: mostly near the path, sometimes anywhere in range
  function automatic logic signed [COORD_BITS-1:0] rnd_coord(
      logic signed [COORD_BITS-1:0] near);
    if ($urandom_range(0, 4) == 0) return COORD_BITS'($urandom);
    return near + COORD_BITS'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic logic [1:0] rnd_mid_func();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return FUNC_START;
    if (r == 1) return FUNC_ODD;
    return FUNC_POINT;
  endfunction

  // receiver: own stall pattern, with quiet stretches and a forced hold-off
  always @(posedge clk) begin
    int phase;
    phase = ($urandom_range(0, 999) + fixes_sent) % 64;
    if (hold_off) out_stall <= 1;
    else if (fixes_sent % 300 < 100) out_stall <= 0;
    else out_stall <= (phase < 20) || ($urandom_range(0, 3) == 0);
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("FAIL track_path_length_accumulator");
      $finish;
    end
  end

  initial begin
    logic signed [COORD_BITS-1:0] cx, cy;
    int len;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: ignored fixes while idle, extremes, odd func, restart
    send_fix(FUNC_POINT, 24'sh7fffff, 24'sh7fffff);
    send_fix(FUNC_STOP, 24'sh0, 24'sh0);
    send_fix(FUNC_ODD, 24'sh1, 24'sh1);
    send_fix(FUNC_START, 24'sh800000, 24'sh800000);
    send_fix(FUNC_POINT, 24'sh7fffff, 24'sh7fffff);
    send_fix(FUNC_START, 24'sh800000, 24'sh7fffff);
    send_fix(FUNC_ODD, 24'sh7fffff, 24'sh800000);
    send_fix(FUNC_STOP, 24'sh7fffff, 24'sh7fffff);
    send_fix(FUNC_START, 24'sh0, 24'sh0);
    send_fix(FUNC_STOP, 24'sh0, 24'sh0);
    send_fix(FUNC_START, 24'sh100, -24'sh100);
    send_fix(FUNC_POINT, 24'sh3ff, 24'sh5);
    send_fix(FUNC_POINT, -24'sh1, 24'shffff);
    send_fix(FUNC_STOP, 24'sh555555, -24'sh2aaaab);

    // pressure: long receiver hold-off while a trip is still offered
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int t = 0; t < 3; t++) begin
          send_fix(FUNC_START, 24'sh10, 24'sh20);
          send_fix(FUNC_POINT, 24'sh7000, 24'sh20);
          send_fix(FUNC_STOP, -24'sh7000, 24'sh10);
        end
      end
    join

    // random trips with noise between them
    while (fixes_sent < 1200) begin
      if ($urandom_range(0, 5) == 0) begin
        send_fix(2'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
        gap();
      end
      cx = COORD_BITS'($urandom);
      cy = COORD_BITS'($urandom);
      send_fix(FUNC_START, cx, cy);
      gap();
      len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 8);
      for (int k = 0; k < len; k++) begin
        cx = rnd_coord(cx);
        cy = rnd_coord(cy);
        send_fix(rnd_mid_func(), cx, cy);
        gap();
      end
      send_fix(FUNC_STOP, rnd_coord(cx), rnd_coord(cy));
      gap();
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d fixes, checked %0d trip results", fixes_sent, trips_seen);
    $display("covered idle noise, restarts mid trip, coordinate extremes and stalls");
    if (fail_count == 0) begin
      $display("PASS track_path_length_accumulator");
    end else begin
      $display("FAIL track_path_length_accumulator");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tpla_pkg.sv
rtl/tpla_sqrt.sv
rtl/tpla_div.sv
rtl/tpla_ctrl.sv
rtl/tpla_dp.sv
rtl/track_path_length_accumulator.sv
dv/tpla_checker.sv
dv/tb_track_path_length_accumulator.sv
